>>> rtl/stph_pkg.sv
// ----------------------------------------------------------------------------
// Two-hop path counter package
// Shared sizes and transfer payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package stph_pkg;
  localparam int unsigned Nodes = 64;
  localparam int unsigned Edges = 1024;
  localparam int unsigned NodeW = $clog2(Nodes);
  localparam int unsigned EdgeW = $clog2(Edges);
  localparam int unsigned LenW = EdgeW + 1;
  localparam int unsigned CntW = 11;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};
  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NodeW-1:0] source_node;
    logic [NodeW-1:0] target_node;
  } in_t;

  typedef struct packed {
    logic [NodeW-1:0] reached_node;
    logic [CntW-1:0]  path_count;
    logic             row_empty;
    logic             last;
  } out_t;
endpackage
`default_nettype wire

>>> rtl/stph_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module stph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/sparse_two_hop_path_counter_unit.sv
// ----------------------------------------------------------------------------
// Sparse two-hop path counter
// Graph in compressed row form; counts two-hop paths per destination.
// ----------------------------------------------------------------------------
// A load transfer is accepted at once and never stalls the next one. A query
// holds the input while it walks the source row and each neighbor's row, and
// an empty row ends in a single empty-row result. The walk runs twice, once to
// count and once to emit and clear, and every edge visited goes through an
// edge read, a counter read and an update.
// Each result also waits in the output register until the consumer takes it,
// and the next transfer is accepted only once the last result has left.
`default_nettype none
module sparse_two_hop_path_counter_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire stph_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output stph_pkg::out_t      out_data_o
);
  localparam int unsigned NW = stph_pkg::NodeW;
  localparam int unsigned EW = stph_pkg::EdgeW;
  localparam int unsigned LW = stph_pkg::LenW;
  localparam int unsigned CW = stph_pkg::CntW;
  localparam int unsigned RW = stph_pkg::NodeW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SRC, S_NBR_RD, S_NBR, S_ROW, S_DST_RD, S_DST, S_CNT, S_OUT, S_EMPTY
  } state_e;

  state_e          state_q;
  logic            pass_q;
  logic [NW-1:0]   src_q, nbr_q, dst_q;
  logic [LW-1:0]   j_q, k_q, slen_q, nlen_q;
  logic [EW-1:0]   sstart_q, nstart_q;
  logic            found_q;
  logic [RW-1:0]   remain_q;
  logic [LW-1:0]   count_q;
  logic            cur_any_q;
  logic [NW-1:0]   cur_src_q;
  logic [stph_pkg::Nodes-1:0] len_valid_q;
  logic [stph_pkg::Nodes-1:0] cnt_valid_q;

  // edge store
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [NW-1:0] e_rdata;
  // row table: start + length
  logic          r_we;
  logic [NW-1:0] r_waddr, r_raddr;
  logic [EW+LW-1:0] r_wdata, r_rdata;
  // counters
  logic          c_we;
  logic [NW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata, c_rdata;

  stph_ram #(.Width(NW), .Depth(stph_pkg::Edges)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(in_data_i.target_node),
    .raddr_i(e_raddr), .rdata_o(e_rdata));
  stph_ram #(.Width(EW+LW), .Depth(stph_pkg::Nodes)) u_row (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata));
  stph_ram #(.Width(CW), .Depth(stph_pkg::Nodes)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata));

  logic in_fire, load_ok, new_row;
  logic [LW-1:0] r_len;
  logic [EW-1:0] r_start;
  logic [CW-1:0] cnt_val;
  logic [EW:0]   idx_sum;
  logic          idx_ok;

  assign in_stall_o = (state_q != S_IDLE) || out_valid_o;
  assign in_fire = in_valid_i && !in_stall_o;
  assign load_ok = (count_q < LW'(stph_pkg::Edges)) &&
                   !(cur_any_q && in_data_i.source_node < cur_src_q);
  assign new_row = !cur_any_q || in_data_i.source_node != cur_src_q;
  assign r_len = len_valid_q[r_raddr] ? r_rdata[LW-1:0] : '0;
  assign r_start = r_rdata[EW+LW-1:LW];
  assign cnt_val = cnt_valid_q[dst_q] ? c_rdata : '0;

  // row table read address follows state
  always_comb begin
    r_raddr = cur_src_q;
    unique case (state_q)
      S_IDLE:   r_raddr = in_data_i.op == stph_pkg::OpQuery ?
                          in_data_i.source_node : cur_src_q;
      S_SRC:    r_raddr = src_q;
      S_NBR_RD, S_NBR: r_raddr = e_rdata;
      default:  r_raddr = nbr_q;
    endcase
  end

  always_comb begin
    idx_sum = '0;
    e_raddr = '0;
    unique case (state_q)
      S_ROW:   idx_sum = {1'b0, nstart_q} + {1'b0, k_q[EW-1:0]};
      default: idx_sum = {1'b0, sstart_q} + {1'b0, j_q[EW-1:0]};
    endcase
    e_raddr = idx_sum[EW-1:0];
    idx_ok = !idx_sum[EW] && (LW'(idx_sum) < count_q);
  end

  // write loads at once, extending the current row from its registered copy
  logic [LW-1:0] run_len_q;
  logic [EW-1:0] run_start_q;
  assign e_we = in_fire && in_data_i.op == stph_pkg::OpLoad && load_ok;
  assign e_waddr = count_q[EW-1:0];
  assign r_we = e_we;
  assign r_waddr = in_data_i.source_node;
  assign r_wdata = new_row ? {count_q[EW-1:0], LW'(1)} :
                             {run_start_q, run_len_q + LW'(1)};

  assign c_raddr = (state_q == S_DST_RD) ? e_rdata : dst_q;
  assign c_waddr = dst_q;
  always_comb begin
    c_we = 1'b0;
    c_wdata = '0;
    if (state_q == S_CNT && !pass_q) begin
      c_we = 1'b1;
      c_wdata = cnt_val == stph_pkg::CountMax ? cnt_val : cnt_val + CW'(1);
    end else if (state_q == S_CNT && pass_q && cnt_val != '0 && !out_valid_o) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q <= 1'b0;
      count_q <= '0;
      cur_any_q <= 1'b0;
      cur_src_q <= '0;
      len_valid_q <= '0;
      cnt_valid_q <= '0;
      out_valid_o <= 1'b0;
      found_q <= 1'b0;
      remain_q <= '0;
      run_len_q <= '0;
      run_start_q <= '0;
      src_q <= '0; nbr_q <= '0; dst_q <= '0;
      j_q <= '0; k_q <= '0; slen_q <= '0; nlen_q <= '0;
      sstart_q <= '0; nstart_q <= '0;
      out_data_o <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (c_we) begin
        cnt_valid_q[c_waddr] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (e_we) begin
            count_q <= count_q + LW'(1);
            cur_any_q <= 1'b1;
            cur_src_q <= in_data_i.source_node;
            len_valid_q[in_data_i.source_node] <= 1'b1;
            run_start_q <= new_row ? count_q[EW-1:0] : run_start_q;
            run_len_q <= new_row ? LW'(1) : run_len_q + LW'(1);
          end else if (in_fire && in_data_i.op == stph_pkg::OpQuery) begin
            src_q <= in_data_i.source_node;
            pass_q <= 1'b0;
            found_q <= 1'b0;
            remain_q <= '0;
            state_q <= S_SRC;
          end
        end
        S_SRC: begin
          slen_q <= len_valid_q[src_q] ? r_rdata[LW-1:0] : '0;
          sstart_q <= r_rdata[EW+LW-1:LW];
          j_q <= '0;
          state_q <= S_NBR_RD;
        end
        S_NBR_RD: begin
          // issue edge read for source slot j
          if (j_q >= slen_q) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
              j_q <= '0;
            end else begin
              state_q <= found_q ? S_IDLE : S_EMPTY;
            end
          end else if (!idx_ok) begin
            j_q <= j_q + LW'(1);
          end else begin
            state_q <= S_NBR;
          end
        end
        S_NBR: begin
          // e_rdata is the neighbor; row table read in flight
          nbr_q <= e_rdata;
          state_q <= S_ROW;
          k_q <= '0;
          nlen_q <= '1;
        end
        S_ROW: begin
          if (nlen_q == '1) begin
            nlen_q <= r_len;
            nstart_q <= r_start;
          end else if (k_q >= nlen_q) begin
            j_q <= j_q + LW'(1);
            state_q <= S_NBR_RD;
          end else if (!idx_ok) begin
            k_q <= k_q + LW'(1);
          end else begin
            state_q <= S_DST_RD;
          end
        end
        S_DST_RD: begin
          dst_q <= e_rdata;
          state_q <= S_DST;
        end
        S_DST: begin
          state_q <= S_CNT;
        end
        S_CNT: begin
          if (!pass_q) begin
            if (cnt_val == '0) begin
              remain_q <= remain_q + RW'(1);
            end
            k_q <= k_q + LW'(1);
            state_q <= S_ROW;
          end else if (cnt_val == '0) begin
            k_q <= k_q + LW'(1);
            state_q <= S_ROW;
          end else if (!out_valid_o) begin
            out_data_o <= '{reached_node: dst_q, path_count: cnt_val,
                            row_empty: 1'b0, last: remain_q == RW'(1)};
            remain_q <= remain_q - RW'(1);
            found_q <= 1'b1;
            k_q <= k_q + LW'(1);
            state_q <= S_ROW;
            out_valid_o <= 1'b1;
          end
        end
        S_EMPTY: begin
          if (!out_valid_o) begin
            out_data_o <= '{reached_node: '0, path_count: '0, row_empty: 1'b1, last: 1'b1};
            out_valid_o <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> dv/sparse_two_hop_path_counter_checker.sv
// ----------------------------------------------------------------------------
// Two-hop path counter checker
// Watches both channels, predicts the results of each query transfer from its
// own copy of the graph, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_two_hop_path_counter_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire stph_pkg::in_t  in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire stph_pkg::out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  logic [stph_pkg::NodeW-1:0] edge_target [stph_pkg::Edges];
  int unsigned      row_first [stph_pkg::Nodes];
  int unsigned      row_len [stph_pkg::Nodes];
  int unsigned      hop_count [stph_pkg::Nodes];
  int unsigned      edge_total;
  int unsigned      cur_src;
  bit               have_edge;
  stph_pkg::out_t   expected_paths [$];

  assign pending_o = expected_paths.size();

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count_o++;
  endtask

  task automatic store_edge(input int unsigned s, input int unsigned d);
    if (edge_total >= stph_pkg::Edges) return;
    if (have_edge && s < cur_src) return;
    if (!have_edge || s > cur_src) begin
      cur_src = s;
      have_edge = 1;
      row_first[s] = edge_total;
      row_len[s] = 1;
    end else begin
      row_len[s]++;
    end
    edge_target[edge_total] = d[stph_pkg::NodeW-1:0];
    edge_total++;
  endtask

  task automatic predict_paths(input int unsigned s);
    int unsigned nbr, dst, n;
    stph_pkg::out_t r;
    n = 0;
    for (int pass = 0; pass < 2; pass++) begin
      for (int unsigned j = 0; j < row_len[s]; j++) begin
        nbr = edge_target[row_first[s] + j];
        for (int unsigned k = 0; k < row_len[nbr]; k++) begin
          dst = edge_target[row_first[nbr] + k];
          if (pass == 0) begin
            if (hop_count[dst] < stph_pkg::CountMax) hop_count[dst]++;
          end else if (hop_count[dst] != 0) begin
            r.reached_node = dst[stph_pkg::NodeW-1:0];
            r.path_count = hop_count[dst][stph_pkg::CntW-1:0];
            r.row_empty = 0;
            r.last = 0;
            expected_paths.push_back(r);
            hop_count[dst] = 0;
            n++;
          end
        end
      end
    end
    if (n == 0) begin
      r = '0;
      r.row_empty = 1;
      r.last = 1;
      expected_paths.push_back(r);
    end else begin
      expected_paths[expected_paths.size()-1].last = 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stph_pkg::out_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      edge_total = 0;
      cur_src = 0;
      have_edge = 0;
      foreach (row_len[i]) row_len[i] = 0;
      foreach (hop_count[i]) hop_count[i] = 0;
      expected_paths.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_paths.size() == 0) begin
          report($sformatf("unexpected result %p", out_data_i));
        end else begin
          e = expected_paths.pop_front();
          if (out_data_i.reached_node !== e.reached_node)
            report($sformatf("reached_node %0d, want %0d", out_data_i.reached_node,
                             e.reached_node));
          if (out_data_i.path_count !== e.path_count)
            report($sformatf("path_count %0d, want %0d", out_data_i.path_count,
                             e.path_count));
          if (out_data_i.row_empty !== e.row_empty)
            report($sformatf("row_empty %0b, want %0b", out_data_i.row_empty, e.row_empty));
          if (out_data_i.last !== e.last)
            report($sformatf("last %0b, want %0b", out_data_i.last, e.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op == stph_pkg::OpLoad)
          store_edge(in_data_i.source_node, in_data_i.target_node);
        else predict_paths(in_data_i.source_node);
      end
    end
  end
endmodule
`default_nettype wire

>>> dv/sparse_two_hop_path_counter_unit_test.sv
// ----------------------------------------------------------------------------
// Two-hop path counter testbench
// Loads graphs edge by edge, including out-of-order and repeated edges, and
// issues queries under three idling regimes; a checker predicts the results.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_two_hop_path_counter_unit_test;
  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            in_valid_i = 0;
  logic            in_stall_o;
  stph_pkg::in_t   in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 0;
  stph_pkg::out_t  out_data_o;
  int    fail_count, pending;
  int    cycle_count = 0;
  int    send_idle = 0, recv_idle = 0;

  always #5 clk_i = ~clk_i;

  sparse_two_hop_path_counter_unit uut (.*);

  sparse_two_hop_path_counter_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= ($urandom_range(99) < recv_idle);
    if (cycle_count > 2000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic op, input int unsigned s, input int unsigned t);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{op: op, source_node: s[stph_pkg::NodeW-1:0],
                   target_node: t[stph_pkg::NodeW-1:0]};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input;
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned s, deg;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(stph_pkg::OpQuery, 0, 0);
    send(stph_pkg::OpQuery, 63, 63);
    send(stph_pkg::OpLoad, 0, 1);
    send(stph_pkg::OpLoad, 0, 1);
    send(stph_pkg::OpLoad, 0, 63);
    send(stph_pkg::OpLoad, 1, 2);
    send(stph_pkg::OpLoad, 1, 0);
    send(stph_pkg::OpLoad, 0, 5);
    send(stph_pkg::OpLoad, 1, 2);
    send(stph_pkg::OpLoad, 2, 0);
    send(stph_pkg::OpLoad, 63, 1);
    send(stph_pkg::OpLoad, 63, 63);
    send(stph_pkg::OpLoad, 5, 5);
    send(stph_pkg::OpQuery, 0, 42);
    send(stph_pkg::OpQuery, 1, 0);
    send(stph_pkg::OpQuery, 63, 0);
    send(stph_pkg::OpQuery, 0, 0);
    send(stph_pkg::OpQuery, 40, 21);
    send(stph_pkg::OpQuery, 2, 0);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 34 : (phase == 1) ? 78 : 0;
      recv_idle = (phase == 0) ? 78 : (phase == 1) ? 34 : 0;
      for (int q = 0; q < 4; q++) begin
        s = $urandom_range(3);
        while (s < 64 && $urandom_range(3) != 0) begin
          deg = $urandom_range(4, 1);
          repeat (deg) begin
            if ($urandom_range(9) == 0)
              send(stph_pkg::OpLoad, $urandom_range(63), $urandom);
            else send(stph_pkg::OpLoad, s, $urandom_range(9) == 0 ? $urandom_range(63)
                                                                    : $urandom_range(15));
          end
          s += $urandom_range(3, 1);
        end
        repeat (3) send(stph_pkg::OpQuery, $urandom_range(9) == 0 ? $urandom_range(63)
                                                                    : $urandom_range(15),
                        $urandom);
      end
    end
    send_idle = 0;
    send(stph_pkg::OpLoad, 63, 0);
    send(stph_pkg::OpQuery, 63, $urandom);
    send(stph_pkg::OpQuery, 0, 0);
    idle_input();
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
rtl/stph_pkg.sv
rtl/stph_ram.sv
rtl/sparse_two_hop_path_counter_unit.sv
dv/sparse_two_hop_path_counter_checker.sv
dv/sparse_two_hop_path_counter_unit_test.sv
